>>> rtl/wtgd_pkg.sv
// shared types, codes and defaults of the wrist tilt gesture detector
package wtgd_pkg;

	localparam int WINDOW_MAX_DEF    = 128;
	localparam int GRAVITY_ALPHA_Q16 = 62259;

	localparam int INDEX_W = 3;
	localparam int CFG_W   = 24;

	typedef enum logic [INDEX_W-1:0] {
		REG_WINDOW_LENGTH    = 3'd0,
		REG_HOLD_SAMPLES     = 3'd1,
		REG_COOLDOWN_SAMPLES = 3'd2,
		REG_SWING_RUNNING    = 3'd3,
		REG_SWING_WALKING    = 3'd4,
		REG_SWING_STATIONARY = 3'd5,
		REG_GYRO_X_THRESHOLD = 3'd6,
		REG_PITCH_TANGENT    = 3'd7
	} reg_index_t;

	typedef enum logic [1:0] {
		CLASS_STATIONARY = 2'd0,
		CLASS_WALKING    = 2'd1,
		CLASS_RUNNING    = 2'd2
	} class_t;

	typedef enum logic [1:0] {
		PHASE_IDLE     = 2'd0,
		PHASE_ACTIVE   = 2'd1,
		PHASE_COOLDOWN = 2'd2
	} phase_t;

	localparam logic [7:0]  WINDOW_LENGTH_RST    = 8'd50;
	localparam logic [23:0] HOLD_SAMPLES_RST     = 24'd50;
	localparam logic [23:0] COOLDOWN_SAMPLES_RST = 24'd100;
	localparam logic [15:0] SWING_RUNNING_RST    = 16'd3000;
	localparam logic [15:0] SWING_WALKING_RST    = 16'd1000;
	localparam logic [15:0] SWING_STATIONARY_RST = 16'd300;
	localparam logic [15:0] GYRO_X_THRESHOLD_RST = 16'd2000;
	localparam logic [19:0] PITCH_TANGENT_RST    = 20'd26000;

endpackage

>>> rtl/wtgd_ram.sv
// generic simple dual-port ram with registered read
module wtgd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/wrist_tilt_gesture_detector_unit.sv
// wrist tilt gesture detector top level: motion window, gravity filter and tilt phase machine
// a sample passes the ring read, classify and fire states; fire waits for a free output
// a new sample is taken only in the idle state, after the last one has left the fire state
// a result waiting in the output register does not block the next input transfer
// reset: arst_n clears all control state and restores the register defaults
// the delta ring memory has no reset; entries are only read once the window has filled them
module wrist_tilt_gesture_detector_unit #(
	parameter int WINDOW_MAX = wtgd_pkg::WINDOW_MAX_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [15:0]           accel_y,
	input  logic signed [15:0]           accel_z,
	input  logic signed [15:0]           gyro_x,
	input  logic [31:0]                  timestamp_ms,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         tilt_fired,
	output logic                         class_changed,
	output logic [1:0]                   motion_class,
	output logic [1:0]                   tilt_phase,
	output logic [31:0]                  event_total,
	output logic [31:0]                  event_time_ms,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [wtgd_pkg::INDEX_W-1:0] cfg_index,
	input  logic [wtgd_pkg::CFG_W-1:0]   cfg_data
);

	import wtgd_pkg::*;

	localparam int HEAD_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int FILL_W  = $clog2(WINDOW_MAX + 1);
	localparam int TOTAL_W = 16 + HEAD_W;
	localparam int PROD_W  = 16 + FILL_W;

	localparam logic signed [17:0] ALPHA_S = 18'(GRAVITY_ALPHA_Q16);
	localparam logic signed [17:0] BETA_S  = 18'(65536 - GRAVITY_ALPHA_Q16);

	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CLASS, ST_FIRE} state_t;

	// rounds half up, floor of the q16 product sum
	function automatic logic signed [31:0] lowpass(logic signed [31:0] g, logic signed [15:0] x);
		logic signed [50:0] t;
		t = ALPHA_S * g + ((BETA_S * x) <<< 16) + 51'sd32768;
		return t[47:16];
	endfunction

	state_t state_q;

	// configuration registers
	logic [7:0]  window_length_q;
	logic [23:0] hold_samples_q, cooldown_samples_q;
	logic [15:0] swing_running_q, swing_walking_q, swing_stationary_q, gyro_x_threshold_q;
	logic [19:0] pitch_tangent_q;

	// block state
	logic [TOTAL_W-1:0] delta_total_q;
	logic [HEAD_W-1:0]  ring_head_q;
	logic [FILL_W-1:0]  ring_fill_q;
	logic signed [15:0] previous_y_q;
	logic               have_previous_q;
	logic signed [31:0] gravity_y_q, gravity_z_q;
	class_t             class_q;
	phase_t             phase_q;
	logic [31:0]        phase_deadline_q, sample_index_q, events_seen_q;

	// per-sample registers
	logic [15:0]        delta_s1, gmag_s1;
	logic [HEAD_W-1:0]  addr_s1;
	logic               have_prev_s1;
	logic signed [15:0] az_s1;
	logic [31:0]        now_s1, ts_s1;
	logic               changed_s2;
	logic [50:0]        pitch_prod_s2;

	// combinational
	logic [FILL_W-1:0]  cap;
	logic [HEAD_W-1:0]  head_eff;
	logic [FILL_W-1:0]  head_nxt;
	logic signed [16:0] dy;
	logic [15:0]        delta_abs;
	logic [15:0]        ram_rdata;
	logic               ram_we;
	logic               in_xfer, cfg_xfer, out_free;
	logic [PROD_W-1:0]  tot_ext, lim_run, lim_walk, lim_stat;
	class_t             class_nxt;
	logic [31:0]        neg_gy;
	logic               pitch_ok, can_fire;
	logic               fire_now;
	phase_t             phase_nxt;
	logic [31:0]        deadline_nxt, events_nxt;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign out_free  = !out_valid || out_ready;

	always_comb begin
		if (window_length_q == 8'd0) begin
			cap = FILL_W'(1);
		end else if (32'(window_length_q) > 32'(WINDOW_MAX)) begin
			cap = FILL_W'(WINDOW_MAX);
		end else begin
			cap = FILL_W'(window_length_q);
		end
	end

	assign head_eff  = (FILL_W'(ring_head_q) >= cap) ? '0 : ring_head_q;
	assign head_nxt  = FILL_W'(addr_s1) + FILL_W'(1);
	assign dy        = 17'(accel_y) - 17'(previous_y_q);
	assign delta_abs = dy[16] ? 16'(-dy) : dy[15:0];
	assign ram_we    = (state_q == ST_READ) && have_prev_s1;

	wtgd_ram #(
		.WIDTH(16),
		.DEPTH(WINDOW_MAX)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_s1),
		.wdata(delta_s1),
		.raddr(head_eff),
		.rdata(ram_rdata)
	);

	// hysteresis classification on the exact average
	always_comb begin
		tot_ext  = PROD_W'(delta_total_q);
		lim_run  = PROD_W'(swing_running_q) * PROD_W'(ring_fill_q);
		lim_walk = PROD_W'(swing_walking_q) * PROD_W'(ring_fill_q);
		lim_stat = PROD_W'(swing_stationary_q) * PROD_W'(ring_fill_q);
		class_nxt = class_q;
		if (ring_fill_q == '0) begin
			if (swing_stationary_q != 16'd0) begin
				class_nxt = CLASS_STATIONARY;
			end
		end else if (tot_ext > lim_run) begin
			class_nxt = CLASS_RUNNING;
		end else if (tot_ext > lim_walk) begin
			class_nxt = CLASS_WALKING;
		end else if (tot_ext < lim_stat) begin
			class_nxt = CLASS_STATIONARY;
		end
	end

	// pitch test without trigonometry
	always_comb begin
		neg_gy = 32'(-gravity_y_q);
		if (!gravity_y_q[31]) begin
			pitch_ok = 1'b1;
		end else if (gravity_z_q[31] || gravity_z_q == 32'sd0) begin
			pitch_ok = 1'b0;
		end else begin
			pitch_ok = pitch_prod_s2 > 51'({neg_gy, 16'd0});
		end
		can_fire = (class_q == CLASS_RUNNING) && ((gmag_s1 > gyro_x_threshold_q) || pitch_ok);
	end

	// next tilt phase, taken in the fire state
	always_comb begin
		fire_now     = 1'b0;
		phase_nxt    = phase_q;
		deadline_nxt = phase_deadline_q;
		unique case (phase_q)
			PHASE_IDLE: begin
				if (can_fire) begin
					fire_now     = 1'b1;
					phase_nxt    = PHASE_ACTIVE;
					deadline_nxt = now_s1 + 32'(hold_samples_q);
				end
			end
			PHASE_ACTIVE: begin
				if (now_s1 >= phase_deadline_q) begin
					phase_nxt    = PHASE_COOLDOWN;
					deadline_nxt = now_s1 + 32'(cooldown_samples_q);
				end
			end
			default: begin
				if (now_s1 >= phase_deadline_q) begin
					phase_nxt = PHASE_IDLE;
				end
			end
		endcase
		events_nxt = events_seen_q + 32'(fire_now);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= ST_IDLE;
			window_length_q    <= WINDOW_LENGTH_RST;
			hold_samples_q     <= HOLD_SAMPLES_RST;
			cooldown_samples_q <= COOLDOWN_SAMPLES_RST;
			swing_running_q    <= SWING_RUNNING_RST;
			swing_walking_q    <= SWING_WALKING_RST;
			swing_stationary_q <= SWING_STATIONARY_RST;
			gyro_x_threshold_q <= GYRO_X_THRESHOLD_RST;
			pitch_tangent_q    <= PITCH_TANGENT_RST;
			delta_total_q      <= '0;
			ring_head_q        <= '0;
			ring_fill_q        <= '0;
			previous_y_q       <= '0;
			have_previous_q    <= 1'b0;
			gravity_y_q        <= '0;
			gravity_z_q        <= '0;
			class_q            <= CLASS_STATIONARY;
			phase_q            <= PHASE_IDLE;
			phase_deadline_q   <= '0;
			sample_index_q     <= '0;
			events_seen_q      <= '0;
			delta_s1           <= '0;
			gmag_s1            <= '0;
			addr_s1            <= '0;
			have_prev_s1       <= 1'b0;
			az_s1              <= '0;
			now_s1             <= '0;
			ts_s1              <= '0;
			changed_s2         <= 1'b0;
			pitch_prod_s2      <= '0;
			out_valid          <= 1'b0;
			tilt_fired         <= 1'b0;
			class_changed      <= 1'b0;
			motion_class       <= '0;
			tilt_phase         <= '0;
			event_total        <= '0;
			event_time_ms      <= '0;
		end else begin
			// the fire state reloads the output register itself
			if (out_valid && out_ready && state_q != ST_FIRE) begin
				out_valid <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						delta_s1        <= delta_abs;
						gmag_s1         <= gyro_x[15] ? 16'(-gyro_x) : gyro_x;
						addr_s1         <= head_eff;
						have_prev_s1    <= have_previous_q;
						az_s1           <= accel_z;
						now_s1          <= sample_index_q;
						ts_s1           <= timestamp_ms;
						sample_index_q  <= sample_index_q + 32'd1;
						previous_y_q    <= accel_y;
						have_previous_q <= 1'b1;
						gravity_y_q     <= lowpass(gravity_y_q, accel_y);
						state_q         <= ST_READ;
					end
				end
				ST_READ: begin
					// ring data for addr_s1 is valid now
					if (have_prev_s1) begin
						if (ring_fill_q >= cap) begin
							delta_total_q <= delta_total_q - TOTAL_W'(ram_rdata)
								+ TOTAL_W'(delta_s1);
						end else begin
							ring_fill_q   <= ring_fill_q + FILL_W'(1);
							delta_total_q <= delta_total_q + TOTAL_W'(delta_s1);
						end
						ring_head_q <= (head_nxt == cap) ? '0 : HEAD_W'(head_nxt);
					end
					gravity_z_q <= lowpass(gravity_z_q, az_s1);
					state_q     <= ST_CLASS;
				end
				ST_CLASS: begin
					class_q       <= class_nxt;
					changed_s2    <= (class_nxt != class_q);
					pitch_prod_s2 <= 51'(gravity_z_q[30:0]) * 51'(pitch_tangent_q);
					state_q       <= ST_FIRE;
				end
				ST_FIRE: begin
					if (out_free) begin
						out_valid        <= 1'b1;
						tilt_fired       <= fire_now;
						class_changed    <= changed_s2;
						motion_class     <= class_q;
						tilt_phase       <= phase_nxt;
						event_total      <= events_nxt;
						event_time_ms    <= ts_s1;
						phase_q          <= phase_nxt;
						phase_deadline_q <= deadline_nxt;
						events_seen_q    <= events_nxt;
						state_q          <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (cfg_xfer) begin
				unique case (reg_index_t'(cfg_index))
					REG_WINDOW_LENGTH: begin
						// window restarts
						window_length_q <= cfg_data[7:0];
						ring_head_q     <= '0;
						ring_fill_q     <= '0;
						delta_total_q   <= '0;
					end
					REG_HOLD_SAMPLES:     hold_samples_q     <= cfg_data[23:0];
					REG_COOLDOWN_SAMPLES: cooldown_samples_q <= cfg_data[23:0];
					REG_SWING_RUNNING:    swing_running_q    <= cfg_data[15:0];
					REG_SWING_WALKING:    swing_walking_q    <= cfg_data[15:0];
					REG_SWING_STATIONARY: swing_stationary_q <= cfg_data[15:0];
					REG_GYRO_X_THRESHOLD: gyro_x_threshold_q <= cfg_data[15:0];
					REG_PITCH_TANGENT:    pitch_tangent_q    <= cfg_data[19:0];
					default: ;
				endcase
			end
		end
	end

endmodule

>>> rtl/wtgd_checker.sv
// port-level checks of the wrist tilt gesture detector, bound to the top level
module wtgd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        tilt_fired,
	input logic [1:0]  motion_class,
	input logic [1:0]  tilt_phase,
	input logic [31:0] event_total,
	input logic [31:0] event_time_ms
);

	import wtgd_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_total)
			&& $stable(event_time_ms) && $stable(tilt_phase))
		else $error("result changed while stalled");

	// a tilt only fires while running and always enters the active phase
	a_fire_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tilt_fired |-> motion_class == CLASS_RUNNING
			&& tilt_phase == PHASE_ACTIVE && event_total != 32'd0)
		else $error("tilt fired outside running or active phase");

	// one sample in flight: no input transfer right after another
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a sample is in flight");

	// a sample transfer leaves no result in the output register before its ring read completes
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind wrist_tilt_gesture_detector_unit wtgd_checker u_wtgd_checker (.*);

>>> tb/sv/wrist_tilt_gesture_detector_unit_tb.sv
// self-checking testbench for the wrist tilt gesture detector: directed corners, random motion, backpressure
`timescale 1ns / 100ps

module wrist_tilt_gesture_detector_unit_tb;

	import wtgd_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_OFF_LEN  = 400;
	localparam int RING_W        = $clog2(WINDOW_MAX_DEF);

	typedef struct packed {
		logic        fired;
		logic        changed;
		class_t      motion;
		phase_t      phase;
		logic [31:0] total;
		logic [31:0] stamp;
	} tilt_outcome_t;

	typedef struct packed {
		reg_index_t  idx;
		logic [23:0] value;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [15:0] accel_y = '0;
	logic signed [15:0] accel_z = '0;
	logic signed [15:0] gyro_x = '0;
	logic [31:0]        timestamp_ms = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               tilt_fired;
	logic               class_changed;
	logic [1:0]         motion_class;
	logic [1:0]         tilt_phase;
	logic [31:0]        event_total;
	logic [31:0]        event_time_ms;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [INDEX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data = '0;

	// idling off for a whole stretch, and a long receiver hold-off
	logic calm = 1'b0;
	logic out_hold = 1'b0;

	tilt_outcome_t awaited_outcomes[$];
	reg_write_t    register_writes[$];
	int unsigned   mismatch_count = 0;
	int unsigned   results_seen = 0;
	int unsigned   cycle_count = 0;
	logic [31:0]   stamp_ms = '0;

	// register mirror
	logic [7:0]  win_len    = WINDOW_LENGTH_RST;
	int unsigned hold_len   = 32'(HOLD_SAMPLES_RST);
	int unsigned cool_len   = 32'(COOLDOWN_SAMPLES_RST);
	int unsigned swing_run  = 32'(SWING_RUNNING_RST);
	int unsigned swing_walk = 32'(SWING_WALKING_RST);
	int unsigned swing_stat = 32'(SWING_STATIONARY_RST);
	int unsigned gyro_thr   = 32'(GYRO_X_THRESHOLD_RST);
	int unsigned pitch_tan  = 32'(PITCH_TANGENT_RST);

	// detector state as predicted
	logic [15:0]        ring_mem [WINDOW_MAX_DEF];
	int unsigned        swing_sum = 0;
	int unsigned        ring_pos = 0;
	int unsigned        ring_count = 0;
	logic signed [15:0] last_y = '0;
	bit                 seen_first = 1'b0;
	longint             grav_y = 0;
	longint             grav_z = 0;
	class_t             cur_class = CLASS_STATIONARY;
	phase_t             cur_phase = PHASE_IDLE;
	int unsigned        phase_end = 0;
	int unsigned        sample_count = 0;
	int unsigned        tilt_count = 0;

	wrist_tilt_gesture_detector_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.accel_y       (accel_y),
		.accel_z       (accel_z),
		.gyro_x        (gyro_x),
		.timestamp_ms  (timestamp_ms),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.tilt_fired    (tilt_fired),
		.class_changed (class_changed),
		.motion_class  (motion_class),
		.tilt_phase    (tilt_phase),
		.event_total   (event_total),
		.event_time_ms (event_time_ms),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// gravity low-pass, Q16.16, floor after adding half
	function automatic longint smooth_gravity(longint g, longint x);
		longint t;
		t = longint'(GRAVITY_ALPHA_Q16) * g
			+ longint'(65536 - GRAVITY_ALPHA_Q16) * (x * 65536) + 32768;
		return t >>> 16;
	endfunction

	function automatic tilt_outcome_t track_wrist_tilt(input logic signed [15:0] ay,
			input logic signed [15:0] az, input logic signed [15:0] gx, input logic [31:0] ts);
		tilt_outcome_t res;
		int unsigned   now_idx, cap, mag;
		int            diff;
		class_t        next_class;
		longint        gyro_mag;
		bit            above_run, above_walk, below_stat, pitch_ok, tilt_ok;
		now_idx = sample_count;
		sample_count++;
		if (win_len == 0)
			cap = 1;
		else if (win_len > WINDOW_MAX_DEF)
			cap = WINDOW_MAX_DEF;
		else
			cap = 32'(win_len);

		// the very first sample only records the previous y
		if (seen_first) begin
			diff = int'(ay) - int'(last_y);
			mag = (diff < 0) ? -diff : diff;
			if (ring_pos >= cap)
				ring_pos = 0;
			if (ring_count >= cap)
				swing_sum -= 32'(ring_mem[RING_W'(ring_pos)]);
			else
				ring_count++;
			ring_mem[RING_W'(ring_pos)] = mag[15:0];
			swing_sum += mag;
			ring_pos = (ring_pos + 1) % cap;
		end else begin
			seen_first = 1'b1;
		end
		last_y = ay;

		// exact average comparisons, hysteresis keeps the class between bands
		if (ring_count == 0) begin
			above_run = 1'b0;
			above_walk = 1'b0;
			below_stat = (swing_stat != 0);
		end else begin
			above_run = longint'(swing_sum) > longint'(swing_run) * longint'(ring_count);
			above_walk = longint'(swing_sum) > longint'(swing_walk) * longint'(ring_count);
			below_stat = longint'(swing_sum) < longint'(swing_stat) * longint'(ring_count);
		end
		next_class = cur_class;
		if (above_run)
			next_class = CLASS_RUNNING;
		else if (above_walk)
			next_class = CLASS_WALKING;
		else if (below_stat)
			next_class = CLASS_STATIONARY;
		res.changed = (next_class != cur_class);
		cur_class = next_class;

		grav_y = smooth_gravity(grav_y, longint'(ay));
		grav_z = smooth_gravity(grav_z, longint'(az));

		if (grav_y >= 0)
			pitch_ok = 1'b1;
		else if (grav_z <= 0)
			pitch_ok = 1'b0;
		else
			pitch_ok = grav_z * longint'(pitch_tan) > (-grav_y) * 65536;
		gyro_mag = (gx < 0) ? -longint'(gx) : longint'(gx);
		tilt_ok = (cur_class == CLASS_RUNNING) && (gyro_mag > longint'(gyro_thr) || pitch_ok);

		res.fired = 1'b0;
		case (cur_phase)
			PHASE_IDLE: begin
				if (tilt_ok) begin
					cur_phase = PHASE_ACTIVE;
					phase_end = now_idx + hold_len;
					tilt_count++;
					res.fired = 1'b1;
				end
			end
			PHASE_ACTIVE: begin
				if (now_idx >= phase_end) begin
					cur_phase = PHASE_COOLDOWN;
					phase_end = now_idx + cool_len;
				end
			end
			default: begin
				if (now_idx >= phase_end)
					cur_phase = PHASE_IDLE;
			end
		endcase

		res.motion = cur_class;
		res.phase = cur_phase;
		res.total = tilt_count;
		res.stamp = ts;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 50)
			$display("[%0t] result %0d: %s", $time, results_seen, msg);
	endtask

	function automatic logic signed [15:0] clip16(input int v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic void stage_write(input reg_index_t idx, input int unsigned value);
		reg_write_t w;
		w.idx = idx;
		w.value = value[23:0];
		register_writes.push_back(w);
	endfunction

	function automatic void stage_profile(input int unsigned win, input int unsigned hold,
			input int unsigned cool, input int unsigned run, input int unsigned walk,
			input int unsigned stat, input int unsigned gyro, input int unsigned pitch);
		stage_write(REG_WINDOW_LENGTH, win);
		stage_write(REG_HOLD_SAMPLES, hold);
		stage_write(REG_COOLDOWN_SAMPLES, cool);
		stage_write(REG_SWING_RUNNING, run);
		stage_write(REG_SWING_WALKING, walk);
		stage_write(REG_SWING_STATIONARY, stat);
		stage_write(REG_GYRO_X_THRESHOLD, gyro);
		stage_write(REG_PITCH_TANGENT, pitch);
	endfunction

	// stop offering samples and wait for every awaited result
	task automatic settle_outcomes();
		in_valid <= 1'b0;
		while (awaited_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic commit_writes();
		reg_write_t w;
		settle_outcomes();
		while (register_writes.size() != 0) begin
			w = register_writes.pop_front();
			cfg_valid <= 1'b1;
			cfg_index <= w.idx;
			cfg_data <= w.value;
			do @(posedge clk); while (!cfg_ready);
			case (w.idx)
				REG_WINDOW_LENGTH: begin
					// the window restarts
					win_len = w.value[7:0];
					ring_pos = 0;
					ring_count = 0;
					swing_sum = 0;
				end
				REG_HOLD_SAMPLES:     hold_len = 32'(w.value);
				REG_COOLDOWN_SAMPLES: cool_len = 32'(w.value);
				REG_SWING_RUNNING:    swing_run = 32'(w.value[15:0]);
				REG_SWING_WALKING:    swing_walk = 32'(w.value[15:0]);
				REG_SWING_STATIONARY: swing_stat = 32'(w.value[15:0]);
				REG_GYRO_X_THRESHOLD: gyro_thr = 32'(w.value[15:0]);
				REG_PITCH_TANGENT:    pitch_tan = 32'(w.value[19:0]);
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_sample(input logic signed [15:0] ay, input logic signed [15:0] az,
			input logic signed [15:0] gx, input logic [31:0] ts);
		if (!calm && $urandom_range(0, 99) < 35) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		accel_y <= ay;
		accel_z <= az;
		gyro_x <= gx;
		timestamp_ms <= ts;
		do @(posedge clk); while (!in_ready);
		awaited_outcomes.push_back(track_wrist_tilt(ay, az, gx, ts));
	endtask

	// segments of still, walking or running motion around a random gravity
	// offset, with some full-range noise mixed in
	task automatic run_motion_bursts(input int unsigned count);
		int unsigned done, seg_len, regime, k;
		int          y_mean, z_mean, amp, jit, y, z, g;
		bit          flip;
		done = 0;
		flip = 1'b0;
		while (done < count) begin
			regime = $urandom_range(0, 9);
			seg_len = $urandom_range(4, 40);
			y_mean = int'($urandom_range(0, 40000)) - 20000;
			z_mean = int'($urandom_range(0, 40000)) - 20000;
			if (regime < 2)
				amp = $urandom_range(0, 150);
			else if (regime < 4)
				amp = $urandom_range(400, 1500);
			else
				amp = $urandom_range(1500, 12000);
			jit = amp / 8 + 1;
			for (k = 0; k < seg_len && done < count; k++) begin
				flip = !flip;
				if ($urandom_range(0, 49) == 0)
					stamp_ms = $urandom;
				else
					stamp_ms += $urandom_range(1, 20);
				if (regime >= 8) begin
					send_sample(16'($urandom), 16'($urandom), 16'($urandom), stamp_ms);
				end else begin
					y = y_mean + (flip ? amp : -amp) + int'($urandom_range(0, 2 * jit)) - jit;
					z = z_mean + int'($urandom_range(0, 400)) - 200;
					if ($urandom_range(0, 7) == 0)
						g = int'($urandom_range(0, 65535)) - 32768;
					else
						g = int'($urandom_range(0, 6000)) - 3000;
					send_sample(clip16(y), clip16(z), clip16(g), stamp_ms);
				end
				done++;
			end
		end
	endtask

	task automatic test_first_samples();
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'd0);
		send_sample(-16'sd32768, 16'sd32767, -16'sd32768, 32'hFFFF_FFFF);
		send_sample(16'sd32767, -16'sd32768, 16'sd32767, 32'd1);
		send_sample(16'sd32767, 16'sd0, 16'sd0, 32'd2);
		send_sample(-16'sd1, 16'sd1, -16'sd1, 32'd3);
	endtask

	task automatic test_window_limits();
		// zero length behaves as one, oversize as the full ring
		stage_write(REG_WINDOW_LENGTH, 0);
		stage_write(REG_HOLD_SAMPLES, 0);
		stage_write(REG_COOLDOWN_SAMPLES, 0);
		commit_writes();
		send_sample(16'sd100, 16'sd0, 16'sd0, 32'd10);
		send_sample(16'sd5000, 16'sd200, 16'sd50, 32'd11);
		send_sample(-16'sd5000, 16'sd400, -16'sd50, 32'd12);
		stage_write(REG_WINDOW_LENGTH, 255);
		commit_writes();
		send_sample(16'sd3000, 16'sd800, 16'sd3000, 32'd20);
		send_sample(-16'sd3000, 16'sd800, -16'sd3000, 32'd21);
		send_sample(16'sd0, 16'sd800, 16'sd0, 32'd22);
	endtask

	task automatic test_threshold_extremes();
		stage_write(REG_SWING_RUNNING, 0);
		stage_write(REG_SWING_WALKING, 0);
		stage_write(REG_SWING_STATIONARY, 0);
		stage_write(REG_GYRO_X_THRESHOLD, 32768);
		stage_write(REG_PITCH_TANGENT, 0);
		commit_writes();
		send_sample(-16'sd8000, 16'sd9000, -16'sd32768, 32'd30);
		send_sample(-16'sd8000, 16'sd9000, 16'sd32767, 32'd31);
		send_sample(-16'sd7000, 16'sd9000, 16'sd0, 32'd32);
		send_sample(-16'sd9000, 16'sd9000, 16'sd100, 32'd33);
		stage_write(REG_SWING_RUNNING, 65535);
		stage_write(REG_SWING_WALKING, 65535);
		stage_write(REG_SWING_STATIONARY, 65535);
		stage_write(REG_GYRO_X_THRESHOLD, 0);
		stage_write(REG_PITCH_TANGENT, 1048575);
		commit_writes();
		send_sample(16'sd32767, 16'sd0, 16'sd1, 32'd40);
		send_sample(-16'sd32768, 16'sd0, -16'sd1, 32'd41);
		send_sample(16'sd32767, 16'sd0, 16'sd0, 32'd42);
		send_sample(16'sd0, -16'sd32768, 16'sd0, 32'd43);
	endtask

	task automatic test_random_settings();
		int unsigned round, stat, walk;
		for (round = 0; round < 6; round++) begin
			case (round)
				0: stage_profile(8, 5, 12, 2500, 900, 250, 1500, 40000);
				1: stage_profile(128, 0, 0, 3000, 1000, 300, 0, 1048575);
				2: stage_profile(1, 3, 3, 0, 0, 0, 32768, 0);
				default: begin
					stat = $urandom_range(0, 1500);
					walk = stat + $urandom_range(0, 2500);
					stage_profile($urandom_range(0, 255), $urandom_range(0, 30),
						$urandom_range(0, 60), walk + $urandom_range(0, 6000), walk, stat,
						$urandom_range(0, 32768), $urandom_range(0, 1048575));
				end
			endcase
			commit_writes();
			calm <= (round == 4);
			run_motion_bursts(70);
		end
		calm <= 1'b0;
	endtask

	task automatic test_output_backpressure();
		fork
			begin
				out_hold <= 1'b1;
				repeat (HOLD_OFF_LEN) @(posedge clk);
				out_hold <= 1'b0;
			end
			run_motion_bursts(60);
		join
	endtask

	task automatic test_endless_phases();
		// once triggered the machine never leaves active
		stage_profile(20, 16777215, 16777215, 2000, 700, 200, 1000, 30000);
		commit_writes();
		run_motion_bursts(40);
	endtask

	// receiving side: checks each result transfer, then picks the next ready
	always @(posedge clk) begin
		tilt_outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (awaited_outcomes.size() == 0) begin
				report_mismatch("result transfer with nothing awaited");
			end else begin
				want = awaited_outcomes.pop_front();
				if (tilt_fired !== want.fired)
					report_mismatch($sformatf("tilt_fired got %0d expected %0d",
						tilt_fired, want.fired));
				if (class_changed !== want.changed)
					report_mismatch($sformatf("class_changed got %0d expected %0d",
						class_changed, want.changed));
				if (motion_class !== want.motion)
					report_mismatch($sformatf("motion_class got %0d expected %0d",
						motion_class, want.motion));
				if (tilt_phase !== want.phase)
					report_mismatch($sformatf("tilt_phase got %0d expected %0d",
						tilt_phase, want.phase));
				if (event_total !== want.total)
					report_mismatch($sformatf("event_total got %0d expected %0d",
						event_total, want.total));
				if (event_time_ms !== want.stamp)
					report_mismatch($sformatf("event_time_ms got %0h expected %0h",
						event_time_ms, want.stamp));
			end
		end
		out_ready <= !out_hold && (calm || $urandom_range(0, 99) >= 35);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", awaited_outcomes.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_first_samples();
		test_window_limits();
		test_threshold_extremes();
		test_random_settings();
		test_output_backpressure();
		test_endless_phases();
		settle_outcomes();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
